/* hdl/histogram_bin_count_percentile_unit_macros.svh */
// assertion macros for the histogram percentile unit checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef HISTOGRAM_BIN_COUNT_PERCENTILE_UNIT_MACROS_SVH
`define HISTOGRAM_BIN_COUNT_PERCENTILE_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define HBCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define HBCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hbcp_pkg.sv */
// shared types, codes and helpers of the histogram percentile unit
// no dependencies
package hbcp_pkg;

    // default sizing
    localparam int DEF_MAX_BINS   = 256;
    localparam int DEF_COUNT_BITS = 32;
    localparam int QUEUE_DEPTH    = 2;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int FRAC_W  = 17;
    localparam int SUM_W   = 64;
    localparam int CFG_IDX_W = 8;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_COUNT      = 2'd0,
        OP_SNAPSHOT   = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_PERCENTILE = 2'd3
    } opcode_t;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NONE      = 2'd1;
    localparam logic [1:0] ST_DECREASED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_SCALE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 8'd3;

    // configuration reset values
    localparam logic [31:0] RST_BIN_SCALE   = 32'd65536;
    localparam logic [8:0]  RST_BINS_IN_USE = 9'd256;

    typedef struct packed {
        logic        scale_mode;
        logic [31:0] min_value;
        logic [31:0] bin_scale;
        logic [8:0]  bins_in_use;
    } cfg_t;

    // saturating 64-bit add
    function automatic logic [SUM_W-1:0] sat_add64(input logic [SUM_W-1:0] x,
                                                   input logic [SUM_W-1:0] y);
        logic [SUM_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

/* hdl/hbcp_fifo.sv */
// short request queue between front and back parts
// depends on nothing but its parameters
module hbcp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (cnt_reg < CW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* hdl/hbcp_front.sv */
// front part: accepts requests and maps count samples to a bin
// depends on hbcp_pkg
module hbcp_front #(
    parameter int MAX_BINS = hbcp_pkg::DEF_MAX_BINS,
    localparam int AW    = $clog2(MAX_BINS),
    localparam int CAP_W = $clog2(MAX_BINS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic signed [31:0]  sample,
    input  logic [16:0]         fraction,
    input  hbcp_pkg::cfg_t      cfg,
    input  logic [CAP_W-1:0]    cap,
    input  logic [AW-1:0]       cap_last,
    output logic                q_valid,
    input  logic                q_ready,
    output logic [1:0]          q_op,
    output logic [AW-1:0]       q_bin,
    output logic [16:0]         q_fraction
);
    import hbcp_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM,
        F_MUL,
        F_RND,
        F_CLAMP,
        F_PUSH
    } fstate_t;

    fstate_t       state_reg;
    logic [1:0]    op_reg;
    logic [16:0]   frac_reg;
    logic          log_reg;
    logic [32:0]   x_reg;
    logic [5:0]    k_reg;
    logic [31:0]   a_reg;
    logic [63:0]   prod_reg;
    logic [47:0]   idx_reg;
    logic [AW-1:0] bin_reg;

    logic [32:0]   off;
    logic [32:0]   off_p1;
    logic          off_le0;
    logic [63:0]   mul_out;
    logic [63:0]   rnd_sum;

    // offset of the sample from the lower bound, exact at 33 bits
    assign off     = {sample[31], sample} - {cfg.min_value[31], cfg.min_value};
    assign off_p1  = off + 33'd1;
    assign off_le0 = off[32] || (off == '0);

    // shared multiplier and rounding
    assign mul_out = 64'(a_reg) * 64'(cfg.bin_scale);
    assign rnd_sum = prod_reg + (log_reg ? 64'h8000_0000 : 64'h8000);

    assign in_ready   = (state_reg == F_IDLE);
    assign q_valid    = (state_reg == F_PUSH);
    assign q_op       = op_reg;
    assign q_bin      = bin_reg;
    assign q_fraction = frac_reg;

    // binning sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            op_reg    <= '0;
            frac_reg  <= '0;
            log_reg   <= 1'b0;
            x_reg     <= '0;
            k_reg     <= '0;
            a_reg     <= '0;
            prod_reg  <= '0;
            idx_reg   <= '0;
            bin_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg   <= opcode;
                        frac_reg <= fraction;
                        log_reg  <= cfg.scale_mode;
                        a_reg    <= off[31:0];
                        x_reg    <= off_p1;
                        k_reg    <= 6'd32;
                        idx_reg  <= '0;
                        bin_reg  <= '0;
                        if (opcode != OP_COUNT)
                        begin
                            state_reg <= F_PUSH;
                        end
                        else if (off_le0)
                        begin
                            state_reg <= F_CLAMP;
                        end
                        else if (cfg.scale_mode)
                        begin
                            state_reg <= F_NORM;
                        end
                        else
                        begin
                            state_reg <= F_MUL;
                        end
                    end
                end
                // leading one search, four places or one place a step
                F_NORM:
                begin
                    if (x_reg[32])
                    begin
                        a_reg     <= {10'd0, k_reg, x_reg[31:16]};
                        state_reg <= F_MUL;
                    end
                    else if (x_reg[32:29] == 4'd0)
                    begin
                        x_reg <= {x_reg[28:0], 4'd0};
                        k_reg <= k_reg - 6'd4;
                    end
                    else
                    begin
                        x_reg <= {x_reg[31:0], 1'b0};
                        k_reg <= k_reg - 6'd1;
                    end
                end
                F_MUL:
                begin
                    prod_reg  <= mul_out;
                    state_reg <= F_RND;
                end
                F_RND:
                begin
                    idx_reg   <= log_reg ? 48'(rnd_sum[63:32]) : rnd_sum[63:16];
                    state_reg <= F_CLAMP;
                end
                F_CLAMP:
                begin
                    bin_reg   <= (idx_reg >= 48'(cap)) ? cap_last : idx_reg[AW-1:0];
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (q_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/hbcp_back.sv */
// back part: counter and snapshot banks, sweeps and percentile walk
// depends on hbcp_pkg
module hbcp_back #(
    parameter int MAX_BINS   = hbcp_pkg::DEF_MAX_BINS,
    parameter int COUNT_BITS = hbcp_pkg::DEF_COUNT_BITS,
    localparam int AW    = $clog2(MAX_BINS),
    localparam int CAP_W = $clog2(MAX_BINS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  logic [1:0]       q_op,
    input  logic [AW-1:0]    q_bin,
    input  logic [16:0]      q_fraction,
    input  logic [CAP_W-1:0] cap,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [7:0]       bin_index
);
    import hbcp_pkg::*;

    typedef enum logic [3:0] {
        B_INIT,
        B_IDLE,
        B_CNT,
        B_SNAP,
        B_CLR,
        B_P1,
        B_PMUL,
        B_PSUM,
        B_P2,
        B_PFIN
    } bstate_t;

    // banks
    logic [COUNT_BITS-1:0] cur_mem  [MAX_BINS];
    logic [COUNT_BITS-1:0] snap_mem [MAX_BINS];
    logic [COUNT_BITS-1:0] cur_q;
    logic [COUNT_BITS-1:0] snap_q;

    bstate_t          state_reg;
    logic [AW-1:0]    addr_reg;
    logic [16:0]      frac_reg;
    logic [CAP_W-1:0] sw_reg;
    logic             pend_reg;
    logic [AW-1:0]    pidx_reg;
    logic [SUM_W-1:0] s1_reg;
    logic [SUM_W-1:0] h_reg;
    logic [SUM_W-1:0] a_reg;
    logic [SUM_W-1:0] b_reg;
    logic [AW-1:0]    lo_reg;
    logic [AW-1:0]    hi_reg;
    logic [63:0]      ph_reg;
    logic [31:0]      pl_reg;
    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [AW-1:0]    bin_reg;

    logic [CAP_W-1:0]      limit;
    logic                  issue;
    logic [AW-1:0]         rd_addr;
    logic [COUNT_BITS-1:0] d;
    logic [SUM_W-1:0]      d64;
    logic                  dec;
    logic [SUM_W-1:0]      s1_add;
    logic [SUM_W-1:0]      a_add;
    logic [SUM_W-1:0]      b_add;
    logic                  hit;
    logic                  cur_we;
    logic [AW-1:0]         cur_wa;
    logic [COUNT_BITS-1:0] cur_wd;
    logic                  snap_we;
    logic [AW-1:0]         snap_wa;
    logic [COUNT_BITS-1:0] snap_wd;
    logic [AW+7:0]         bin_ext;

    // sweep address and walk arithmetic
    always_comb
    begin
        limit   = ((state_reg == B_P1) || (state_reg == B_P2)) ? cap : CAP_W'(MAX_BINS);
        issue   = (sw_reg < limit);
        rd_addr = (state_reg == B_IDLE) ? q_bin : sw_reg[AW-1:0];
        d       = cur_q - snap_q;
        d64     = SUM_W'(d);
        dec     = (cur_q < snap_q);
        s1_add  = sat_add64(s1_reg, d64);
        a_add   = sat_add64(a_reg, d64);
        b_add   = sat_add64(b_reg, d64);
        hit     = (a_reg <= h_reg) && (h_reg <= b_add);
    end

    // bank write control
    always_comb
    begin
        cur_we  = 1'b0;
        cur_wa  = sw_reg[AW-1:0];
        cur_wd  = '0;
        snap_we = 1'b0;
        snap_wa = sw_reg[AW-1:0];
        snap_wd = '0;
        case (state_reg)
            B_CNT:
            begin
                cur_we = 1'b1;
                cur_wa = addr_reg;
                cur_wd = (cur_q == {COUNT_BITS{1'b1}}) ? cur_q : cur_q + 1'b1;
            end
            B_INIT, B_CLR:
            begin
                cur_we  = issue;
                snap_we = issue;
            end
            B_SNAP:
            begin
                snap_we = pend_reg;
                snap_wa = pidx_reg;
                snap_wd = cur_q;
            end
            default:
            begin
                cur_we  = 1'b0;
                snap_we = 1'b0;
            end
        endcase
    end

    // current counter bank
    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_wa] <= cur_wd;
        end
        cur_q <= cur_mem[rd_addr];
    end

    // snapshot bank
    always_ff @(posedge clk)
    begin
        if (snap_we)
        begin
            snap_mem[snap_wa] <= snap_wd;
        end
        snap_q <= snap_mem[rd_addr];
    end

    assign q_ready   = (state_reg == B_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign bin_ext   = (AW + 8)'(bin_reg);
    assign bin_index = bin_ext[7:0];

    // operation sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            addr_reg      <= '0;
            frac_reg      <= '0;
            sw_reg        <= '0;
            pend_reg      <= 1'b0;
            pidx_reg      <= '0;
            s1_reg        <= '0;
            h_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            ph_reg        <= '0;
            pl_reg        <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            bin_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                // clearing pass after reset
                B_INIT:
                begin
                    if (issue)
                    begin
                        sw_reg <= sw_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    sw_reg   <= '0;
                    pend_reg <= 1'b0;
                    s1_reg   <= '0;
                    a_reg    <= '0;
                    b_reg    <= '0;
                    lo_reg   <= '0;
                    hi_reg   <= '0;
                    if (q_valid && q_ready)
                    begin
                        addr_reg <= q_bin;
                        frac_reg <= q_fraction;
                        case (opcode_t'(q_op))
                            OP_COUNT:      state_reg <= B_CNT;
                            OP_SNAPSHOT:   state_reg <= B_SNAP;
                            OP_CLEAR:      state_reg <= B_CLR;
                            OP_PERCENTILE: state_reg <= B_P1;
                            default:       state_reg <= B_IDLE;
                        endcase
                    end
                end
                // read-modify-write of one counter
                B_CNT:
                begin
                    out_valid_reg <= 1'b1;
                    status_reg    <= ST_OK;
                    bin_reg       <= addr_reg;
                    state_reg     <= B_IDLE;
                end
                // copy counters into the snapshot bank
                B_SNAP:
                begin
                    pend_reg <= issue;
                    pidx_reg <= sw_reg[AW-1:0];
                    if (issue)
                    begin
                        sw_reg <= sw_reg + 1'b1;
                    end
                    else if (!pend_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= ST_OK;
                        bin_reg       <= '0;
                        state_reg     <= B_IDLE;
                    end
                end
                B_CLR:
                begin
                    if (issue)
                    begin
                        sw_reg <= sw_reg + 1'b1;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= ST_OK;
                        bin_reg       <= '0;
                        state_reg     <= B_IDLE;
                    end
                end
                // first pass: decrease check and total
                B_P1:
                begin
                    if (pend_reg && dec)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= ST_DECREASED;
                        bin_reg       <= '0;
                        state_reg     <= B_IDLE;
                    end
                    else
                    begin
                        if (pend_reg)
                        begin
                            s1_reg <= s1_add;
                        end
                        pend_reg <= issue;
                        pidx_reg <= sw_reg[AW-1:0];
                        if (issue)
                        begin
                            sw_reg <= sw_reg + 1'b1;
                        end
                        else if (!pend_reg)
                        begin
                            state_reg <= B_PMUL;
                        end
                    end
                end
                // target rank from the total and the fraction
                B_PMUL:
                begin
                    ph_reg    <= 64'(s1_reg[63:16]) * 64'(frac_reg[15:0]);
                    pl_reg    <= 32'(s1_reg[15:0]) * 32'(frac_reg[15:0]);
                    state_reg <= B_PSUM;
                end
                B_PSUM:
                begin
                    h_reg     <= (frac_reg >= FRAC_ONE) ? s1_reg
                                                        : ph_reg + 64'(pl_reg[31:16]);
                    sw_reg    <= '0;
                    pend_reg  <= 1'b0;
                    state_reg <= B_P2;
                end
                // second pass: find the bin that holds the rank
                B_P2:
                begin
                    if (pend_reg && hit)
                    begin
                        hi_reg    <= pidx_reg;
                        b_reg     <= b_add;
                        state_reg <= B_PFIN;
                    end
                    else
                    begin
                        if (pend_reg)
                        begin
                            hi_reg <= pidx_reg;
                            lo_reg <= pidx_reg;
                            a_reg  <= a_add;
                            b_reg  <= b_add;
                        end
                        pend_reg <= issue;
                        pidx_reg <= sw_reg[AW-1:0];
                        if (issue)
                        begin
                            sw_reg <= sw_reg + 1'b1;
                        end
                        else if (!pend_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            status_reg    <= ST_NONE;
                            bin_reg       <= '0;
                            state_reg     <= B_IDLE;
                        end
                    end
                end
                B_PFIN:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= B_IDLE;
                    if ((s1_reg != '0) && (a_reg < b_reg) && (lo_reg < hi_reg))
                    begin
                        status_reg <= ST_OK;
                        bin_reg    <= (h_reg == b_reg) ? hi_reg : lo_reg;
                    end
                    else
                    begin
                        status_reg <= ST_NONE;
                        bin_reg    <= '0;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/histogram_bin_count_percentile_unit.sv */
// top level of the histogram bin counter with percentile query
// depends on hbcp_pkg, hbcp_front, hbcp_fifo, hbcp_back
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid in_ready opcode sample fraction | request in
//  out     | out_valid out_ready status bin_index     | result out
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | write in
//
// count: front runs multiply, round, clamp and queue push in linear mode, with a
//   leading one search first in log mode; back does the counter read-modify-write
// snapshot and clear sweep every bank entry, percentile the bins in use
//   (two walks over the banks, one bin a cycle through the read port)
// after reset a clearing pass runs before the first request
//   is executed; requests are still queued meanwhile
// a waiting result holds the back; once the queue is full the front and the input stall
module histogram_bin_count_percentile_unit #(
    parameter int MAX_BINS   = hbcp_pkg::DEF_MAX_BINS,
    parameter int COUNT_BITS = hbcp_pkg::DEF_COUNT_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] sample,
    input  logic [16:0]        fraction,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [7:0]         bin_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import hbcp_pkg::*;

    localparam int AW    = $clog2(MAX_BINS);
    localparam int CAP_W = $clog2(MAX_BINS + 1);
    localparam int BW    = (CAP_W > 9) ? CAP_W : 9;
    localparam int QW    = OP_W + AW + FRAC_W;

    cfg_t             cfg_reg;
    logic [BW-1:0]    biu;
    logic [CAP_W-1:0] cap;
    logic [AW-1:0]    cap_last;

    logic             fq_valid;
    logic             fq_ready;
    logic [1:0]       fq_op;
    logic [AW-1:0]    fq_bin;
    logic [16:0]      fq_frac;
    logic [QW-1:0]    fq_data;
    logic             bq_valid;
    logic             bq_ready;
    logic [QW-1:0]    bq_data;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_mode  <= 1'b0;
            cfg_reg.min_value   <= '0;
            cfg_reg.bin_scale   <= RST_BIN_SCALE;
            cfg_reg.bins_in_use <= RST_BINS_IN_USE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCALE_MODE:  cfg_reg.scale_mode  <= cfg_data[0];
                REG_MIN_VALUE:   cfg_reg.min_value   <= cfg_data;
                REG_BIN_SCALE:   cfg_reg.bin_scale   <= cfg_data;
                REG_BINS_IN_USE: cfg_reg.bins_in_use <= cfg_data[8:0];
                default:         cfg_reg.scale_mode  <= cfg_reg.scale_mode;
            endcase
        end
    end

    // bins in use, held between one and the bank depth
    always_comb
    begin
        biu = BW'(cfg_reg.bins_in_use);
        if (biu == '0)
        begin
            cap = CAP_W'(1);
        end
        else if (biu > BW'(MAX_BINS))
        begin
            cap = CAP_W'(MAX_BINS);
        end
        else
        begin
            cap = biu[CAP_W-1:0];
        end
        cap_last = AW'(cap - 1'b1);
    end

    hbcp_front #(
        .MAX_BINS (MAX_BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .sample     (sample),
        .fraction   (fraction),
        .cfg        (cfg_reg),
        .cap        (cap),
        .cap_last   (cap_last),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_op       (fq_op),
        .q_bin      (fq_bin),
        .q_fraction (fq_frac)
    );

    assign fq_data = {fq_op, fq_bin, fq_frac};

    hbcp_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    hbcp_back #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (bq_valid),
        .q_ready    (bq_ready),
        .q_op       (bq_data[QW-1 -: OP_W]),
        .q_bin      (bq_data[FRAC_W +: AW]),
        .q_fraction (bq_data[FRAC_W-1:0]),
        .cap        (cap),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .bin_index  (bin_index)
    );

endmodule

/* hdl/hbcp_checker.sv */
// port checker of the histogram percentile unit, bound to the top level
// depends on hbcp_pkg and histogram_bin_count_percentile_unit_macros.svh
`include "histogram_bin_count_percentile_unit_macros.svh"

module hbcp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  opcode,
    input logic [31:0] sample,
    input logic [16:0] fraction,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  bin_index,
    input logic        cfg_ready
);
    import hbcp_pkg::*;

    logic        in_stall;
    logic [50:0] in_word;
    logic        out_stall;
    logic [9:0]  out_word;
    logic        status_known;
    logic        fail_clean;

    assign in_stall     = in_valid && !in_ready;
    assign in_word      = {opcode, sample, fraction};
    assign out_stall    = out_valid && !out_ready;
    assign out_word     = {status, bin_index};
    assign status_known = (status == ST_OK) || (status == ST_NONE) || (status == ST_DECREASED);
    assign fail_clean   = (status == ST_OK) || (bin_index == 8'd0);

    // a stalled request stays
    `HBCP_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(in_word), "stalled request changed")
    // a stalled result stays
    `HBCP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled result changed")
    // status is one of the three codes
    `HBCP_ASSERT(a_status_code, !out_valid || status_known, "bad status code")
    // a failed query carries no bin
    `HBCP_ASSERT(a_fail_zero, !out_valid || fail_clean, "bin set on failure")
    // configuration port never stalls
    `HBCP_ASSERT(a_cfg_ready, cfg_ready, "config port stalled")
endmodule

bind histogram_bin_count_percentile_unit hbcp_checker u_hbcp_checker (.*);
